/* rtl/ring_nearest_address_search_macros.svh */
// Assertion macros for the ring nearest-address search block.
// Included by the top level only; no other dependencies.
`ifndef RING_NEAREST_ADDRESS_SEARCH_MACROS_SVH
`define RING_NEAREST_ADDRESS_SEARCH_MACROS_SVH

// cond must never hold outside reset
`define RNAS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define RNAS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// ante in a cycle implies cons in the next cycle
`define RNAS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rnas_pkg.sv */
// Shared types and codes for the ring nearest-address search block.
// No dependencies; used by rnas_store, rnas_dist and the top level.
package rnas_pkg;

    localparam int ADDR_W = 16;

    // opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // one scanned entry with its distance to the target
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] gap;
    } cand_t;

endpackage

/* rtl/rnas_store.sv */
// Address table: synchronous single-write, single-read memory with a registered read port.
// Depends on rnas_pkg for the address width.
module rnas_store #(
    parameter int DEPTH = 256,
    parameter int IW    = 8
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [IW-1:0]             waddr,
    input  logic [rnas_pkg::ADDR_W-1:0] wdata,
    input  logic                      re,
    input  logic [IW-1:0]             raddr,
    output logic [rnas_pkg::ADDR_W-1:0] rdata
);

    logic [rnas_pkg::ADDR_W-1:0] mem [DEPTH];
    logic [rnas_pkg::ADDR_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rnas_dist.sv */
// Circular distance stage: one stored address against the target, registered.
// Depends on rnas_pkg for cand_t.
module rnas_dist #(
    parameter int RING_SIZE = 65536
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [rnas_pkg::ADDR_W-1:0] in_addr,
    input  logic [rnas_pkg::ADDR_W-1:0] target,
    output rnas_pkg::cand_t             cand
);

    localparam logic [16:0] RING17 = 17'(RING_SIZE);

    logic [16:0] diff;
    logic [16:0] wrap;
    logic [16:0] dmin;
    rnas_pkg::cand_t cand_reg;

    // |a-b| and the way around the other side
    always_comb begin
        if (in_addr >= target) begin
            diff = {1'b0, in_addr} - {1'b0, target};
        end else begin
            diff = {1'b0, target} - {1'b0, in_addr};
        end
        wrap = RING17 - diff;
        dmin = (diff < wrap) ? diff : wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.valid <= 1'b0;
        end else begin
            cand_reg.valid <= in_valid;
        end
        cand_reg.addr <= in_addr;
        cand_reg.gap  <= dmin[15:0];
    end

    assign cand = cand_reg;

endmodule

/* rtl/ring_nearest_address_search.sv */
// Top level of the ring nearest-address search: control sequencer, scan compare, output register.
// Depends on rnas_pkg, rnas_store, rnas_dist and ring_nearest_address_search_macros.svh.
//
//  channel | dir | handshake          | beat contents
//  s_      | in  | s_tvalid/s_tready  | opcode, ring_address
//  m_      | out | m_tvalid/m_tready  | nearest_address, ring_distance, status
//
// Each beat goes through modulo reduction in S_MUL and S_RED, then insert and query scan
// the table at one entry per cycle through the memory read port; clear and unused opcodes
// skip the scan and go straight from S_RED to S_DONE.
// The table memory has no reset; of the table state only count_reg is cleared by aresetn.
// A held result stalls the sequencer only at its final step; the next beat is taken
// while the result waits in the output register.
`include "ring_nearest_address_search_macros.svh"

module ring_nearest_address_search #(
    parameter int MAX_NODES = 256,
    parameter int RING_SIZE = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] opcode, [17:2] ring_address, [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [15:0] nearest_address, [31:16] ring_distance,
                                   // [33:32] status, [39:34] zero
);

    localparam int AW = rnas_pkg::ADDR_W;
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NODES);
    localparam logic [16:0] RING17 = 17'(RING_SIZE);
    // floor(2^32 / RING_SIZE): quotient estimate is exact or one low
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / RING_SIZE);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_RED, S_SCAN, S_DONE} state_t;

    state_t          state_reg;
    logic [1:0]      op_reg;
    logic [AW-1:0]   addr_reg;
    logic [AW-1:0]   quot_reg;
    logic [AW-1:0]   target_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   rd_idx_reg;
    logic            rv1_reg;
    logic            best_valid_reg;
    logic [AW-1:0]   best_addr_reg;
    logic [AW-1:0]   best_dist_reg;
    logic            found_reg;
    logic [AW-1:0]   res_near_reg;
    logic [AW-1:0]   res_dist_reg;
    logic [1:0]      res_status_reg;
    logic            m_tvalid_reg;
    logic [39:0]     m_tdata_reg;

    logic [48:0]     prod;
    logic [32:0]     qr;
    logic [16:0]     rem_raw;
    logic [16:0]     rem_fix;
    logic            issue;
    logic            scan_done;
    logic            mem_we;
    logic            take;
    logic            out_free;
    logic [AW-1:0]   rdata;
    rnas_pkg::cand_t cand;

    // address reduction modulo the ring size
    always_comb begin
        prod    = 49'(addr_reg) * 49'(RECIP);
        qr      = 33'(quot_reg) * 33'(RING17);
        rem_raw = {1'b0, addr_reg} - qr[16:0];
        rem_fix = (rem_raw >= RING17) ? (rem_raw - RING17) : rem_raw;
    end

    // scan and write-back control
    always_comb begin
        issue     = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);
        scan_done = (state_reg == S_SCAN) && !issue && !rv1_reg && !cand.valid;
        mem_we    = scan_done && (op_reg == rnas_pkg::OP_INSERT) && !found_reg
                    && (count_reg < MAX_CNT);
        take      = s_tvalid && s_tready;
        out_free  = !m_tvalid_reg || m_tready;
    end

    rnas_store #(
        .DEPTH (MAX_NODES),
        .IW    (IW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (target_reg),
        .re    (issue),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    rnas_dist #(
        .RING_SIZE (RING_SIZE)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rv1_reg),
        .in_addr  (rdata),
        .target   (target_reg),
        .cand     (cand)
    );

    // sequencer, scan compare and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            rv1_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            rv1_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            // keep the closest candidate; ties go to the lower address
            if (cand.valid) begin
                if (!best_valid_reg || (cand.gap < best_dist_reg)
                    || ((cand.gap == best_dist_reg) && (cand.addr < best_addr_reg))) begin
                    best_valid_reg <= 1'b1;
                    best_addr_reg  <= cand.addr;
                    best_dist_reg  <= cand.gap;
                end
                if (cand.gap == '0) begin
                    found_reg <= 1'b1;
                end
            end

            // drop the result once taken; in S_DONE the next result replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        op_reg    <= s_tdata[1:0];
                        addr_reg  <= s_tdata[17:2];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    quot_reg  <= prod[47:32];
                    state_reg <= S_RED;
                end
                S_RED: begin
                    target_reg     <= rem_fix[AW-1:0];
                    rd_idx_reg     <= '0;
                    best_valid_reg <= 1'b0;
                    found_reg      <= 1'b0;
                    res_near_reg   <= '0;
                    res_dist_reg   <= '0;
                    res_status_reg <= rnas_pkg::ST_OK;
                    if (op_reg == rnas_pkg::OP_INSERT || op_reg == rnas_pkg::OP_QUERY) begin
                        state_reg <= S_SCAN;
                    end else begin
                        if (op_reg == rnas_pkg::OP_CLEAR) begin
                            count_reg <= '0;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        if (op_reg == rnas_pkg::OP_QUERY) begin
                            if (count_reg == '0) begin
                                res_status_reg <= rnas_pkg::ST_EMPTY;
                            end else begin
                                res_near_reg <= best_addr_reg;
                                res_dist_reg <= best_dist_reg;
                            end
                        end else if (found_reg) begin
                            res_status_reg <= rnas_pkg::ST_DUP;
                        end else if (count_reg >= MAX_CNT) begin
                            res_status_reg <= rnas_pkg::ST_FULL;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, res_status_reg, res_dist_reg, res_near_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `RNAS_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > MAX_CNT, "entry count above table size")
    `RNAS_ASSERT_SAME(a_we_room, aclk, aresetn, mem_we, (count_reg < MAX_CNT) && (op_reg == rnas_pkg::OP_INSERT), "table write without room")
    `RNAS_ASSERT_SAME(a_cand_in_scan, aclk, aresetn, cand.valid || rv1_reg, state_reg == S_SCAN, "scan pipeline busy outside scan")
    `RNAS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second beat taken before reduction")

endmodule

/* dv/ring_nearest_address_search_tb.sv */
// Self-checking bench for ring_nearest_address_search: drives clear, insert, query and unused-opcode
// beats with random gaps and stalls, and checks each result against a scoreboard model.
// Depends on rnas_pkg and the ring_nearest_address_search top level.
module ring_nearest_address_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH    = 256;
    localparam int unsigned RING_POSITIONS = 65536;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          TARGET_BEATS   = 1850;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          SETTLE_CYCLES  = 300;
    localparam int          MAX_REPORTS    = 10;

    // result fields in m_tdata order, top member in the highest bits
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] gap;
        logic [15:0] addr;
    } ring_result_t;

    // shadow address table and queue of expected results
    class nearest_address_scoreboard;
        logic [15:0]  ring_table[TABLE_DEPTH];
        int unsigned  table_fill;
        ring_result_t pending_results[$];
        int unsigned  mismatch_count;
        int unsigned  result_count;

        function new();
            table_fill     = 0;
            mismatch_count = 0;
            result_count   = 0;
        endfunction

        // circular distance between two ring positions
        function int unsigned ring_gap(logic [15:0] a, logic [15:0] b);
            int unsigned d;
            d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
            return (d < RING_POSITIONS - d) ? d : RING_POSITIONS - d;
        endfunction

        // update the table for an accepted beat and queue its expected result
        function void note_beat(logic [1:0] op, logic [15:0] addr);
            ring_result_t want;
            bit           seen;
            int unsigned  best_d;
            int unsigned  d;
            int           i;
            want = '0;
            case (op)
                rnas_pkg::OP_CLEAR: begin
                    table_fill = 0;
                end
                rnas_pkg::OP_INSERT: begin
                    seen = 1'b0;
                    for (i = 0; i < int'(table_fill); i++) begin
                        if (ring_table[i] == addr) seen = 1'b1;
                    end
                    if (seen) begin
                        want.status = rnas_pkg::ST_DUP;
                    end else if (table_fill >= TABLE_DEPTH) begin
                        want.status = rnas_pkg::ST_FULL;
                    end else begin
                        ring_table[table_fill] = addr;
                        table_fill++;
                    end
                end
                rnas_pkg::OP_QUERY: begin
                    if (table_fill == 0) begin
                        want.status = rnas_pkg::ST_EMPTY;
                    end else begin
                        best_d = 32'hFFFF_FFFF;
                        // ascending walk; on a tie the smaller address wins
                        for (i = 0; i < int'(table_fill); i++) begin
                            d = ring_gap(ring_table[i], addr);
                            if (d < best_d || (d == best_d && ring_table[i] < want.addr)) begin
                                best_d    = d;
                                want.addr = ring_table[i];
                            end
                        end
                        want.gap = best_d[15:0];
                    end
                end
                default: ;
            endcase
            pending_results = {pending_results, want};
        endfunction

        function void report(string what, ring_result_t want, ring_result_t got);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch %0d (%s): want %h/%h/%0d got %h/%h/%0d",
                         result_count, what, want.addr, want.gap, want.status,
                         got.addr, got.gap, got.status);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [39:0] beat);
            ring_result_t got;
            ring_result_t want;
            got = beat[33:0];
            if (pending_results.size() == 0) begin
                report("no result pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.addr != want.addr)     report("nearest_address", want, got);
                if (got.gap != want.gap)       report("ring_distance", want, got);
                if (got.status != want.status) report("status", want, got);
            end
            result_count++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [1:0] opcode, [17:2] ring_address, [23:18] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [15:0] nearest_address, [31:16] ring_distance, [33:32] status

    nearest_address_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned quiet_cycles;
    int unsigned beats_sent;

    ring_nearest_address_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: random backpressure at the current stall rate
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // result monitor and watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // one input beat; returns at the falling edge after it was accepted
    task automatic send_beat(input logic [1:0] op, input logic [15:0] addr);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, addr, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(op, addr);
        if (op != OP_UNUSED) beats_sent++;
        @(negedge aclk);
    endtask

    // hold the sender off until every expected result has come back
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [15:0] stored_addr();
        return sb.ring_table[$urandom_range(sb.table_fill - 1, 0)];
    endfunction

    // one randomly chosen operation, weighted toward queries near stored entries
    task automatic random_op;
        int unsigned r;
        int unsigned sum;
        logic [15:0] a;
        r = $urandom_range(99, 0);
        if (r < 45) begin
            if (sb.table_fill > 0) a = stored_addr() + 16'($urandom_range(64, 0)) - 16'd32;
            else                   a = 16'($urandom);
            send_beat(rnas_pkg::OP_QUERY, a);
        end else if (r < 55) begin
            send_beat(rnas_pkg::OP_QUERY, 16'($urandom));
        end else if (r < 60) begin
            // midpoint of two stored entries often gives a tie
            if (sb.table_fill > 0) begin
                sum = int'(stored_addr()) + int'(stored_addr());
                a   = 16'(sum >> 1);
            end else begin
                a = 16'($urandom);
            end
            send_beat(rnas_pkg::OP_QUERY, a);
        end else if (r < 75) begin
            send_beat(rnas_pkg::OP_INSERT, 16'($urandom));
        end else if (r < 85) begin
            send_beat(rnas_pkg::OP_INSERT, (sb.table_fill > 0) ? stored_addr() : 16'($urandom));
        end else if (r < 90) begin
            case ($urandom_range(2, 0))
                0:       a = 16'h0000;
                1:       a = 16'hFFFF;
                default: a = 16'h8000;
            endcase
            send_beat(rnas_pkg::OP_QUERY, a);
        end else if (r < 94) begin
            send_beat(rnas_pkg::OP_CLEAR, 16'($urandom));
        end else if (r < 97) begin
            send_beat(OP_UNUSED, 16'($urandom));
        end else begin
            send_beat(rnas_pkg::OP_INSERT, $urandom_range(1, 0) ? 16'hFFFF : 16'h0000);
        end
    endtask

    initial begin
        int unsigned episode;
        int unsigned fill_goal;
        int unsigned op_count;
        int          k;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        beats_sent     = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty query, unused opcode, ring wrap, ties, maximum distance
        send_beat(rnas_pkg::OP_QUERY,  16'h1234);
        send_beat(OP_UNUSED,           16'hFFFF);
        send_beat(OP_UNUSED,           16'h0000);
        send_beat(rnas_pkg::OP_INSERT, 16'h0000);
        send_beat(rnas_pkg::OP_INSERT, 16'hFFFF);
        send_beat(rnas_pkg::OP_INSERT, 16'h8000);
        send_beat(rnas_pkg::OP_INSERT, 16'h0000);
        send_beat(rnas_pkg::OP_QUERY,  16'h4000);
        send_beat(rnas_pkg::OP_QUERY,  16'hC000);
        send_beat(rnas_pkg::OP_QUERY,  16'hFFFE);
        send_beat(rnas_pkg::OP_QUERY,  16'h0001);
        send_beat(rnas_pkg::OP_QUERY,  16'h8000);
        send_beat(rnas_pkg::OP_CLEAR,  16'hFFFF);
        send_beat(rnas_pkg::OP_QUERY,  16'h0000);
        send_beat(rnas_pkg::OP_INSERT, 16'h1234);
        send_beat(rnas_pkg::OP_QUERY,  16'h9234);
        send_beat(rnas_pkg::OP_QUERY,  16'h1234);
        send_beat(rnas_pkg::OP_INSERT, 16'h5555);
        send_beat(rnas_pkg::OP_INSERT, 16'hAAAA);
        send_beat(rnas_pkg::OP_QUERY,  16'h7FFF);
        send_beat(rnas_pkg::OP_QUERY,  16'h0000);
        send_beat(rnas_pkg::OP_CLEAR,  16'h0000);
        wait_for_results();

        // random episodes: fill to a size, then a mix of operations
        episode = 0;
        while (beats_sent < TARGET_BEATS) begin
            case (episode % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (episode % 6 == 0) wait_for_results();
            if ($urandom_range(3, 0) != 0) send_beat(rnas_pkg::OP_CLEAR, 16'($urandom));
            if (episode % 16 == 7) begin
                // fill the table completely, then push against the limit
                fill_goal = TABLE_DEPTH;
                op_count  = 12;
            end else begin
                fill_goal = sb.table_fill + $urandom_range(12, 1);
                op_count  = $urandom_range(30, 10);
            end
            while (sb.table_fill < fill_goal && sb.table_fill < TABLE_DEPTH)
                send_beat(rnas_pkg::OP_INSERT, 16'($urandom));
            if (sb.table_fill == TABLE_DEPTH) begin
                send_beat(rnas_pkg::OP_INSERT, 16'($urandom));
                send_beat(rnas_pkg::OP_INSERT, stored_addr());
            end
            for (k = 0; k < int'(op_count); k++) random_op();
            episode++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
